// ===== rtl/gsdd_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the grid shift density derivative unit
package gsdd_pkg;

   localparam int MAX_CELLS = 4096;
   localparam int IDX_W     = $clog2(MAX_CELLS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int MASS_W    = 32;
   localparam int DER_W     = 48;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [CNT_W-1:0] CELLS_RESET = CNT_W'(MAX_CELLS);
   localparam logic [31:0]      INV_WIDTH_RESET = 32'd65536;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHANNEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_WIDTH    = 2'd1;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_READ, ST_MUL, ST_REM_START, ST_REM_WAIT,
      ST_INIT, ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE, DP_CLEAR, DP_LOAD, DP_READ, DP_MUL, DP_REM_START, DP_INIT,
      DP_C0, DP_C1, DP_C2, DP_C3, DP_C4, DP_C5, DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rem_busy;
      logic last_cell;
      logic rsp_free;
   } status_type;

endpackage

// ===== rtl/gsdd_if.sv =====
`timescale 1ns / 1ps
// channel interfaces: input items, result items and register writes
interface gsdd_req_if import gsdd_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [IDX_W-1:0]         cell_index;
   logic signed [MASS_W-1:0] mass_value;
   logic [31:0]              rate;
   logic signed [31:0]       efficacy;
   modport source (output valid, kind, cell_index, mass_value, rate, efficacy,
                   input ready);
   modport sink (input valid, kind, cell_index, mass_value, rate, efficacy,
                 output ready);
endinterface

interface gsdd_rsp_if import gsdd_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic signed [DER_W-1:0] derivative_value;
   logic                    saturated;
   modport source (output valid, derivative_value, saturated, input ready);
   modport sink (input valid, derivative_value, saturated, output ready);
endinterface

interface gsdd_csr_if import gsdd_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gsdd_rem.sv =====
`timescale 1ns / 1ps
// serial restoring remainder unit, one quotient bit per cycle
module gsdd_rem import gsdd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             busy,
   output logic [IDX_W-1:0] remainder
);
   logic [CNT_W:0]   rem_ff, rem_in;
   logic [31:0]      quo_ff, quo_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic [CNT_W:0]   trial;

   always_comb begin
      trial  = {rem_ff[CNT_W-1:0], quo_ff[31]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = 6'd32;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         quo_in = {quo_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         run_in = (cnt_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy      = run_ff;
   assign remainder = rem_ff[IDX_W-1:0];
endmodule

// ===== rtl/gsdd_dp.sv =====
`timescale 1ns / 1ps
// datapath: mass and derivative stores, shift setup and per-cell accumulate
module gsdd_dp import gsdd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   gsdd_req_if.sink   req,
   input  logic       req_accept,
   gsdd_rsp_if.source rsp,
   gsdd_csr_if.sink   csr
);
   // item fields
   logic [KIND_W-1:0]        kind_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic signed [MASS_W-1:0] mass_ff;
   logic [31:0]              rate_ff;
   logic signed [31:0]       eff_ff;

   // registers
   logic [CNT_W-1:0] cells_ff;
   logic [31:0]      icw_ff;

   // stores
   logic signed [MASS_W-1:0] mass_mem [MAX_CELLS];
   logic signed [DER_W-1:0]  der_mem  [MAX_CELLS];
   logic [IDX_W-1:0]         mraddr;
   logic signed [MASS_W-1:0] mrd_ff;
   logic signed [DER_W-1:0]  drd_ff;
   logic                     der_we;
   logic [IDX_W-1:0]         der_waddr;
   logic signed [DER_W-1:0]  der_wdata;

   // channel setup
   logic [CNT_W-1:0] n_ff, n_in;
   logic [63:0]      p_ff;
   logic             pos_ff;
   logic [IDX_W-1:0] a_ff, b_ff, i_ff, clr_ff;
   logic [IDX_W-1:0] k1, k2, a_next, b_next;
   logic [CNT_W-1:0] n_last;
   logic             rem_busy;
   logic [31:0]      mag;
   logic [32:0]      stays;

   // per-cell pipeline
   logic signed [65:0] p1_ff, p2_ff, p1_in, p2_in, mix, mix_r;
   logic signed [33:0] mix30;
   logic signed [34:0] d_ff, d_in;
   logic [34:0]        dmag;
   logic [65:0]        prod_full;
   logic [63:0]        prod_ff;
   logic               dneg_ff;
   logic [48:0]        tmag;
   logic signed [49:0] term;
   logic signed [50:0] sum51;
   logic               ovf;
   logic signed [DER_W-1:0] acc;
   logic               sat_ff;

   logic                    rsp_valid_ff;
   logic signed [DER_W-1:0] rsp_der_ff;
   logic                    rsp_sat_ff;

   assign csr.ready = 1'b1;
   assign n_last    = n_ff - CNT_W'(1);
   assign mag       = eff_ff[31] ? 32'(-eff_ff) : 32'(eff_ff);
   assign stays     = 33'h1_0000_0000 - {1'b0, p_ff[31:0]};

   gsdd_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.op == DP_REM_START),
      .dividend  (p_ff[63:32]),
      .divisor   (n_ff),
      .busy      (rem_busy),
      .remainder (k1)
   );

   always_comb begin
      if (cells_ff < CNT_W'(2))           n_in = CNT_W'(2);
      else if (cells_ff > CELLS_RESET)    n_in = CELLS_RESET;
      else                                n_in = cells_ff;
      k2     = ({1'b0, k1} == n_last) ? '0 : k1 + IDX_W'(1);
      a_next = ({1'b0, a_ff} == n_last) ? '0 : a_ff + IDX_W'(1);
      b_next = ({1'b0, b_ff} == n_last) ? '0 : b_ff + IDX_W'(1);
   end

   // mass read address
   always_comb begin
      unique case (cmd.op)
         DP_C0:   mraddr = a_ff;
         DP_C1:   mraddr = b_ff;
         DP_C2:   mraddr = i_ff;
         default: mraddr = i_ff;
      endcase
   end

   // arithmetic of one cell
   always_comb begin
      p1_in = $signed({1'b0, stays}) * mrd_ff;
      p2_in = $signed({2'b0, p_ff[31:0]}) * mrd_ff;
      mix   = p1_ff + p2_ff;
      mix_r = mix + 66'sd2147483648;
      mix30 = mix_r[65:32];
      d_in  = {mix30[33], mix30} - {{3{mrd_ff[31]}}, mrd_ff};
      dmag  = d_ff[34] ? 35'(-d_ff) : 35'(d_ff);
      prod_full = dmag[33:0] * rate_ff;
      tmag  = {1'b0, prod_ff[63:16]} + 49'(prod_ff[15]);
      term  = dneg_ff ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
      sum51 = {{3{drd_ff[47]}}, drd_ff} + {term[49], term};
      ovf   = !(sum51[50:47] == 4'b0000 || sum51[50:47] == 4'b1111);
      if (!ovf)           acc = sum51[47:0];
      else if (sum51[50]) acc = {1'b1, {(DER_W-1){1'b0}}};
      else                acc = {1'b0, {(DER_W-1){1'b1}}};
   end

   // derivative write port
   always_comb begin
      der_we    = 1'b0;
      der_waddr = i_ff;
      der_wdata = '0;
      unique case (cmd.op)
         DP_CLEAR: begin
            der_we    = 1'b1;
            der_waddr = clr_ff;
         end
         DP_LOAD: begin
            der_we    = 1'b1;
            der_waddr = idx_ff;
         end
         DP_C5: begin
            der_we    = 1'b1;
            der_wdata = acc;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) mass_mem[idx_ff] <= mass_ff;
      mrd_ff <= mass_mem[mraddr];
      if (der_we) der_mem[der_waddr] <= der_wdata;
      if (cmd.op == DP_READ)    drd_ff <= der_mem[idx_ff];
      else if (cmd.op == DP_C2) drd_ff <= der_mem[i_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff     <= CELLS_RESET;
         icw_ff       <= INV_WIDTH_RESET;
         clr_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid && csr.index == CSR_CELLS_IN_USE) cells_ff <= csr.data[CNT_W-1:0];
         if (csr.valid && csr.index == CSR_INV_WIDTH)    icw_ff   <= csr.data;
         if (cmd.op == DP_CLEAR) clr_ff <= clr_ff + IDX_W'(1);
         if (cmd.op == DP_LOAD)  sat_ff <= 1'b0;
         else if (cmd.op == DP_C5 && ovf) sat_ff <= 1'b1;
         if (cmd.op == DP_RESULT) rsp_valid_ff <= 1'b1;
         else if (rsp.ready)      rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff <= req.kind;
         idx_ff  <= req.cell_index;
         mass_ff <= req.mass_value;
         rate_ff <= req.rate;
         eff_ff  <= req.efficacy;
      end
      unique case (cmd.op)
         DP_MUL: begin
            p_ff   <= mag * icw_ff;
            n_ff   <= n_in;
            pos_ff <= !eff_ff[31] && (eff_ff != '0);
         end
         DP_INIT: begin
            i_ff <= '0;
            a_ff <= (pos_ff && k1 != '0) ? IDX_W'(n_ff - {1'b0, k1}) : k1;
            b_ff <= (pos_ff && k2 != '0) ? IDX_W'(n_ff - {1'b0, k2}) : k2;
         end
         DP_C1: p1_ff <= p1_in;
         DP_C2: p2_ff <= p2_in;
         DP_C3: d_ff  <= d_in;
         DP_C4: begin
            prod_ff <= prod_full[63:0];
            dneg_ff <= d_ff[34];
         end
         DP_C5: begin
            i_ff <= i_ff + IDX_W'(1);
            a_ff <= a_next;
            b_ff <= b_next;
         end
         DP_RESULT: begin
            rsp_der_ff <= (kind_ff == KIND_READ) ? drd_ff : '0;
            rsp_sat_ff <= (cmd.op == DP_RESULT) ? sat_ff : rsp_sat_ff;
         end
         default: ;
      endcase
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.derivative_value = rsp_der_ff;
   assign rsp.saturated        = rsp_sat_ff;

   assign status.clear_last = (clr_ff == {IDX_W{1'b1}});
   assign status.rem_busy   = rem_busy;
   assign status.last_cell  = ({1'b0, i_ff} == n_last);
   assign status.rsp_free   = !rsp_valid_ff || rsp.ready;
endmodule

// ===== rtl/gsdd_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences clearing, loads, reads and the channel sweep
module gsdd_ctrl import gsdd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   output logic              req_ready,
   input  status_type        status,
   output cmd_type           cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = DP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_kind)
                  KIND_LOAD:    state_in = ST_LOAD;
                  KIND_CHANNEL: state_in = ST_MUL;
                  KIND_READ:    state_in = ST_READ;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.op   = DP_LOAD;
            state_in = ST_DONE;
         end
         ST_READ: begin
            cmd.op   = DP_READ;
            state_in = ST_DONE;
         end
         ST_MUL: begin
            cmd.op   = DP_MUL;
            state_in = ST_REM_START;
         end
         ST_REM_START: begin
            cmd.op   = DP_REM_START;
            state_in = ST_REM_WAIT;
         end
         ST_REM_WAIT: begin
            if (!status.rem_busy) state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.op   = DP_INIT;
            state_in = ST_C0;
         end
         ST_C0: begin cmd.op = DP_C0; state_in = ST_C1; end
         ST_C1: begin cmd.op = DP_C1; state_in = ST_C2; end
         ST_C2: begin cmd.op = DP_C2; state_in = ST_C3; end
         ST_C3: begin cmd.op = DP_C3; state_in = ST_C4; end
         ST_C4: begin cmd.op = DP_C4; state_in = ST_C5; end
         ST_C5: begin
            cmd.op   = DP_C5;
            state_in = status.last_cell ? ST_DONE : ST_C0;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.op   = DP_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== rtl/grid_shift_density_derivative_unit.sv =====
`timescale 1ns / 1ps
// top level of the grid shift density derivative unit
// the unit holds a 4096-cell mass grid and its derivative grid. a load item
// stores one mass cell, clears its derivative and the saturation flag; a
// channel item sweeps cells 0 to n-1 (n = cells_in_use clamped to 2..4096)
// adding rate*(stays*mass[i+s1] + goes*mass[i+s2] - mass[i]) with a clamp
// to the signed 48-bit range; a read item returns one derivative. every item
// gives one result item. after reset a clearing pass zeroes the derivative
// store cell by cell, during which no item is accepted; register writes
// are taken at any time. the length of a channel item is set by the
// 32-step serial remainder that wraps the whole shift and by the single
// mass read port, which needs three reads per cell feeding a six-step
// multiply and accumulate sequence. one item is in work at a time; a
// finished result waits in the output register while the next item is
// accepted
module grid_shift_density_derivative_unit import gsdd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   gsdd_req_if.sink   req_ch,
   gsdd_rsp_if.source rsp_ch,
   gsdd_csr_if.sink   csr_ch
);
   cmd_type    cmd;
   status_type status;
   logic       req_accept;

   // item handshake
   assign req_accept = req_ch.valid && req_ch.ready;

   // sequencing of clear, load, read and the channel sweep
   gsdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, arithmetic, registers and result register
   gsdd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req        (req_ch),
      .req_accept (req_accept),
      .rsp        (rsp_ch),
      .csr        (csr_ch)
   );
endmodule
